// ===== rtl/core/bgdt_pkg.sv =====
// Shared types, constants and helper functions of the grid distance transform.
// Used by every module under rtl/core; depends on nothing else.
package bgdt_pkg;

	localparam int MAX_WIDTH    = 64;
	localparam int MAX_HEIGHT   = 64;
	localparam int SNAP_RADIUS  = 12;
	localparam int STORE_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int IDX_W        = 12;
	localparam int DIST_W       = 13;
	localparam int CRD_W        = 6;
	localparam int DIM_W        = 7;
	localparam int RAD_W        = 4;
	localparam int OFS_W        = 6;
	localparam logic [DIST_W-1:0] DIST_MAX    = 13'd4095;
	localparam logic [DIST_W-1:0] DIST_UNREACH = '1;

	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_RUN    = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_OUTSIDE = 2'd1;
	localparam logic [1:0] ST_NOFREE  = 2'd2;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_UNKNOWN = 2'd2;
	localparam logic [1:0] REG_THRESH = 2'd3;

	typedef struct packed {
		logic [1:0]        op;
		logic [IDX_W-1:0]  cell_index;
		logic signed [7:0] cell_value;
		logic signed [7:0] start_x;
		logic signed [7:0] start_y;
	} in_t;

	typedef struct packed {
		logic signed [DIST_W-1:0] distance;
		logic [1:0]               status;
		logic [CRD_W-1:0]         used_start_x;
		logic [CRD_W-1:0]         used_start_y;
	} out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic grid_wr;
		logic dist_rd_in;
		logic latch_start;
		logic clr_step;
		logic start_rd;
		logic snap_init;
		logic snap_rd;
		logic snap_adv;
		logic snap_take;
		logic seed;
		logic pop;
		logic cur_latch;
		logic cur_rd;
		logic curd_latch;
		logic nb_rd;
		logic nb_adv;
		logic nb_upd;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic start_out;
		logic grid_free;
		logic cand_in;
		logic snap_last;
		logic q_empty;
		logic nb_in;
		logic nb_last;
	} sts_t;

	// Output slot control from the controller to the top level.
	typedef struct packed {
		logic       load;
		logic [1:0] status;
		logic       sel_dist;
		logic       sel_xy;
	} oload_t;

	function automatic logic [IDX_W-1:0] cell_addr(input logic [CRD_W-1:0] y,
			input logic [CRD_W-1:0] x, input logic [DIM_W-1:0] w);
		logic [IDX_W:0] p;
		p = ({{(IDX_W+1-CRD_W){1'b0}}, y} * {{(IDX_W+1-DIM_W){1'b0}}, w})
			+ {{(IDX_W+1-CRD_W){1'b0}}, x};
		return p[IDX_W-1:0];
	endfunction

	function automatic logic cell_free(input logic signed [7:0] v,
			input logic signed [7:0] unk, input logic signed [7:0] thr);
		return (v != unk) && (v >= 8'sd0) && (v < thr);
	endfunction

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input int maxv);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > DIM_W'(maxv))
			r = DIM_W'(maxv);
		return r;
	endfunction

endpackage

// ===== rtl/core/bgdt_dpath.sv =====
// Datapath of the distance transform: grid, distance and frontier memories,
// sweep and snap counters, and neighbor generation. Depends on bgdt_pkg.
module bgdt_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bgdt_pkg::cmd_t                cmd,
	input  bgdt_pkg::in_t                 in_item,
	input  logic [bgdt_pkg::DIM_W-1:0]    w_eff,
	input  logic [bgdt_pkg::DIM_W-1:0]    h_eff,
	input  logic signed [7:0]             unk,
	input  logic signed [7:0]             thr,
	output bgdt_pkg::sts_t                sts,
	output logic [bgdt_pkg::DIST_W-1:0]   rd_dist,
	output logic [bgdt_pkg::CRD_W-1:0]    used_x,
	output logic [bgdt_pkg::CRD_W-1:0]    used_y
);
	import bgdt_pkg::*;

	logic [7:0]        grid_mem [STORE_DEPTH];
	logic [DIST_W-1:0] dist_mem [STORE_DEPTH];
	logic [IDX_W-1:0]  queue_mem [STORE_DEPTH];

	logic [7:0]        grid_rd_q;
	logic [DIST_W-1:0] dist_rd_q;
	logic [IDX_W-1:0]  queue_rd_q;

	logic [IDX_W-1:0]  cnt_q, clr_end_q;
	logic signed [7:0] sx_q, sy_q;
	logic [RAD_W-1:0]  r_q;
	logic signed [OFS_W-1:0] dx_q, dy_q;
	logic [CRD_W-1:0]  cur_x_q, cur_y_q;
	logic [DIST_W-1:0] curd_q;
	logic [1:0]        dir_q;
	logic [IDX_W:0]    head_q, tail_q;
	logic [IDX_W-1:0]  nidx_q;

	logic signed [7:0] cand_x, cand_y, nb_x, nb_y;
	logic signed [7:0] w_s, h_s;
	logic [IDX_W-1:0]  start_idx, cand_idx, cur_idx, nb_idx;
	logic [IDX_W-1:0]  grid_raddr, dist_raddr, dist_waddr;
	logic [DIST_W-1:0] dist_wdata, nd;
	logic              dist_we, nb_ok, push;
	logic [DIM_W+DIM_W-1:0] area;

	assign w_s = $signed({1'b0, w_eff});
	assign h_s = $signed({1'b0, h_eff});
	assign cand_x = sx_q + {{(8-OFS_W){dx_q[OFS_W-1]}}, dx_q};
	assign cand_y = sy_q + {{(8-OFS_W){dy_q[OFS_W-1]}}, dy_q};

	always_comb begin
		nb_x = $signed({2'b00, cur_x_q});
		nb_y = $signed({2'b00, cur_y_q});
		case (dir_q)
			2'd0:    nb_x = nb_x + 8'sd1;
			2'd1:    nb_x = nb_x - 8'sd1;
			2'd2:    nb_y = nb_y + 8'sd1;
			default: nb_y = nb_y - 8'sd1;
		endcase
	end

	assign start_idx = cell_addr(sy_q[CRD_W-1:0], sx_q[CRD_W-1:0], w_eff);
	assign cand_idx  = cell_addr(cand_y[CRD_W-1:0], cand_x[CRD_W-1:0], w_eff);
	assign cur_idx   = cell_addr(cur_y_q, cur_x_q, w_eff);
	assign nb_idx    = cell_addr(nb_y[CRD_W-1:0], nb_x[CRD_W-1:0], w_eff);
	assign area      = w_eff * h_eff;

	assign sts.clr_last  = (cnt_q == clr_end_q);
	assign sts.start_out = (sx_q < 8'sd0) || (sx_q >= w_s) || (sy_q < 8'sd0) || (sy_q >= h_s);
	assign sts.grid_free = cell_free(grid_rd_q, unk, thr);
	assign sts.cand_in   = (cand_x >= 8'sd0) && (cand_x < w_s) && (cand_y >= 8'sd0)
		&& (cand_y < h_s);
	assign sts.snap_last = (dx_q == OFS_W'(r_q)) && (dy_q == OFS_W'(r_q))
		&& (r_q == RAD_W'(SNAP_RADIUS));
	assign sts.q_empty   = (head_q == tail_q);
	assign sts.nb_in     = (nb_x >= 8'sd0) && (nb_x < w_s) && (nb_y >= 8'sd0) && (nb_y < h_s);
	assign sts.nb_last   = (dir_q == 2'd3);

	assign nb_ok = (dist_rd_q == DIST_UNREACH) && sts.grid_free;
	assign nd    = (curd_q == DIST_MAX) ? DIST_MAX : curd_q + DIST_W'(1);
	assign push  = cmd.nb_upd && nb_ok && (tail_q < (IDX_W+1)'(STORE_DEPTH));

	assign rd_dist = dist_rd_q;
	assign used_x  = sx_q[CRD_W-1:0];
	assign used_y  = sy_q[CRD_W-1:0];

	always_comb begin
		grid_raddr = nb_idx;
		if (cmd.start_rd)
			grid_raddr = start_idx;
		else if (cmd.snap_rd)
			grid_raddr = cand_idx;
		dist_raddr = nb_idx;
		if (cmd.dist_rd_in)
			dist_raddr = in_item.cell_index;
		else if (cmd.cur_rd)
			dist_raddr = cur_idx;
		dist_we    = 1'b0;
		dist_waddr = nidx_q;
		dist_wdata = nd;
		if (cmd.clr_step) begin
			dist_we    = 1'b1;
			dist_waddr = cnt_q;
			dist_wdata = DIST_UNREACH;
		end else if (cmd.seed) begin
			dist_we    = 1'b1;
			dist_waddr = start_idx;
			dist_wdata = '0;
		end else if (cmd.nb_upd && nb_ok) begin
			dist_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.grid_wr)
			grid_mem[in_item.cell_index] <= in_item.cell_value;
		grid_rd_q <= grid_mem[grid_raddr];
	end

	always_ff @(posedge clk) begin
		if (dist_we)
			dist_mem[dist_waddr] <= dist_wdata;
		dist_rd_q <= dist_mem[dist_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.seed)
			queue_mem[0] <= {sy_q[CRD_W-1:0], sx_q[CRD_W-1:0]};
		else if (push)
			queue_mem[tail_q[IDX_W-1:0]] <= {nb_y[CRD_W-1:0], nb_x[CRD_W-1:0]};
		queue_rd_q <= queue_mem[head_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			clr_end_q <= IDX_W'(STORE_DEPTH - 1);
			head_q    <= '0;
			tail_q    <= '0;
		end else begin
			if (cmd.latch_start) begin
				cnt_q     <= '0;
				clr_end_q <= IDX_W'(area - 1'b1);
			end else if (cmd.clr_step && !sts.clr_last) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.seed) begin
				head_q <= '0;
				tail_q <= (IDX_W+1)'(1);
			end else begin
				if (cmd.pop)
					head_q <= head_q + 1'b1;
				if (push)
					tail_q <= tail_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_start) begin
			sx_q <= in_item.start_x;
			sy_q <= in_item.start_y;
		end else if (cmd.snap_take) begin
			sx_q <= cand_x;
			sy_q <= cand_y;
		end
		if (cmd.snap_init) begin
			r_q  <= RAD_W'(1);
			dy_q <= -OFS_W'(1);
			dx_q <= -OFS_W'(1);
		end else if (cmd.snap_adv) begin
			if (dx_q != OFS_W'(r_q)) begin
				dx_q <= dx_q + 1'b1;
			end else if (dy_q != OFS_W'(r_q)) begin
				dy_q <= dy_q + 1'b1;
				dx_q <= -OFS_W'(r_q);
			end else begin
				r_q  <= r_q + 1'b1;
				dy_q <= -OFS_W'(r_q + 1'b1);
				dx_q <= -OFS_W'(r_q + 1'b1);
			end
		end
		if (cmd.cur_latch)
			{cur_y_q, cur_x_q} <= queue_rd_q;
		if (cmd.curd_latch) begin
			curd_q <= dist_rd_q;
			dir_q  <= 2'd0;
		end else if (cmd.nb_adv) begin
			dir_q <= dir_q + 1'b1;
		end
		if (cmd.nb_rd)
			nidx_q <= nb_idx;
	end

endmodule

// ===== rtl/core/bgdt_ctrl.sv =====
// Controller state machine of the distance transform: sequences clearing,
// start check, snapping and the breadth-first search. Depends on bgdt_pkg.
module bgdt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [1:0]      in_op,
	input  logic            slot_free,
	input  bgdt_pkg::sts_t  sts,
	output logic            in_ready,
	output bgdt_pkg::cmd_t  cmd,
	output bgdt_pkg::oload_t oload
);
	import bgdt_pkg::*;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_RD, S_RCLR, S_CHK, S_START_T, S_SN_ADDR, S_SN_T,
		S_SEED, S_POP, S_POPW, S_CURD, S_DLAT, S_NADDR, S_NT
	} state_t;

	state_t state_q, state_d;
	logic   take;

	assign in_ready = (state_q == S_IDLE) && slot_free;
	assign take     = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		oload   = '0;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (take) begin
					unique case (in_op)
						OP_WRITE: begin
							cmd.grid_wr = 1'b1;
							oload.load  = 1'b1;
						end
						OP_READ: begin
							cmd.dist_rd_in = 1'b1;
							state_d        = S_RD;
						end
						OP_RUN: begin
							cmd.latch_start = 1'b1;
							state_d         = S_RCLR;
						end
						default: oload.load = 1'b1;
					endcase
				end
			end
			S_RD: begin
				oload.load     = 1'b1;
				oload.sel_dist = 1'b1;
				state_d        = S_IDLE;
			end
			S_RCLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last)
					state_d = S_CHK;
			end
			S_CHK: begin
				if (sts.start_out) begin
					oload.load   = 1'b1;
					oload.status = ST_OUTSIDE;
					state_d      = S_IDLE;
				end else begin
					cmd.start_rd = 1'b1;
					state_d      = S_START_T;
				end
			end
			S_START_T: begin
				if (sts.grid_free) begin
					state_d = S_SEED;
				end else if (SNAP_RADIUS == 0) begin
					oload.load   = 1'b1;
					oload.status = ST_NOFREE;
					oload.sel_xy = 1'b1;
					state_d      = S_IDLE;
				end else begin
					cmd.snap_init = 1'b1;
					state_d       = S_SN_ADDR;
				end
			end
			S_SN_ADDR: begin
				if (sts.cand_in) begin
					cmd.snap_rd = 1'b1;
					state_d     = S_SN_T;
				end else if (sts.snap_last) begin
					oload.load   = 1'b1;
					oload.status = ST_NOFREE;
					oload.sel_xy = 1'b1;
					state_d      = S_IDLE;
				end else begin
					cmd.snap_adv = 1'b1;
				end
			end
			S_SN_T: begin
				if (sts.grid_free) begin
					cmd.snap_take = 1'b1;
					state_d       = S_SEED;
				end else if (sts.snap_last) begin
					oload.load   = 1'b1;
					oload.status = ST_NOFREE;
					oload.sel_xy = 1'b1;
					state_d      = S_IDLE;
				end else begin
					cmd.snap_adv = 1'b1;
					state_d      = S_SN_ADDR;
				end
			end
			S_SEED: begin
				cmd.seed = 1'b1;
				state_d  = S_POP;
			end
			S_POP: begin
				if (sts.q_empty) begin
					oload.load   = 1'b1;
					oload.status = ST_DONE;
					oload.sel_xy = 1'b1;
					state_d      = S_IDLE;
				end else begin
					cmd.pop = 1'b1;
					state_d = S_POPW;
				end
			end
			S_POPW: begin
				cmd.cur_latch = 1'b1;
				state_d       = S_CURD;
			end
			S_CURD: begin
				cmd.cur_rd = 1'b1;
				state_d    = S_DLAT;
			end
			S_DLAT: begin
				cmd.curd_latch = 1'b1;
				state_d        = S_NADDR;
			end
			S_NADDR: begin
				if (sts.nb_in) begin
					cmd.nb_rd = 1'b1;
					state_d   = S_NT;
				end else if (sts.nb_last) begin
					state_d = S_POP;
				end else begin
					cmd.nb_adv = 1'b1;
				end
			end
			S_NT: begin
				cmd.nb_upd = 1'b1;
				if (sts.nb_last) begin
					state_d = S_POP;
				end else begin
					cmd.nb_adv = 1'b1;
					state_d    = S_NADDR;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_CLR;
		else
			state_q <= state_d;
	end

endmodule

// ===== rtl/core/bfs_grid_distance_transform_top.sv =====
// Top level of the 4-connected grid distance transform: configuration
// registers, output slot, controller and datapath. Depends on bgdt_pkg.
//
// Usage: one input channel (in_valid/in_stall/in_data) carries operations:
// cell write, transform run, and distance read. Every accepted transaction
// gives exactly one result on the output channel (out_valid/out_stall/
// out_data). Writes and unused op codes return a result in the cycle after
// acceptance; reads first pass through the distance memory read register.
// A run sweeps the distance entries of the w*h cells in use to unreachable,
// tries snap candidates if the start cell is not free (squares of radius 1
// to 12, each scanned in full), then pops each reached cell, reads its
// distance and reads and updates its in-grid neighbors. One item is in work
// at a time; the next is taken as soon as the result slot is free or being
// emptied in the same cycle. After reset all 4096 distance memory entries
// are swept to unreachable, during which in_stall is high. When the receiver
// stalls, the result is held in the output register and no new transaction
// is taken until it leaves. Configuration (cfg_we/cfg_index/cfg_data) must
// be written only while the block is idle; the block does not enforce it.
module bfs_grid_distance_transform_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  bgdt_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output bgdt_pkg::out_t  out_data,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_index,
	input  logic [7:0]      cfg_data
);
	import bgdt_pkg::*;

	logic [DIM_W-1:0]  width_q, height_q, w_eff, h_eff;
	logic signed [7:0] unk_q, thr_q;
	logic              out_valid_q, slot_free, in_ready;
	out_t              out_q;
	cmd_t              cmd;
	sts_t              sts;
	oload_t            oload;
	logic [DIST_W-1:0] rd_dist;
	logic [CRD_W-1:0]  used_x, used_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(64);
			height_q <= DIM_W'(64);
			unk_q    <= -8'sd1;
			thr_q    <= 8'sd50;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:   width_q  <= cfg_data[DIM_W-1:0];
				REG_HEIGHT:  height_q <= cfg_data[DIM_W-1:0];
				REG_UNKNOWN: unk_q    <= cfg_data;
				REG_THRESH:  thr_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign w_eff = clamp_dim(width_q, MAX_WIDTH);
	assign h_eff = clamp_dim(height_q, MAX_HEIGHT);

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = !in_ready;

	bgdt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_op     (in_data.op),
		.slot_free (slot_free),
		.sts       (sts),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.oload     (oload)
	);

	bgdt_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.in_item (in_data),
		.w_eff   (w_eff),
		.h_eff   (h_eff),
		.unk     (unk_q),
		.thr     (thr_q),
		.sts     (sts),
		.rd_dist (rd_dist),
		.used_x  (used_x),
		.used_y  (used_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (oload.load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (oload.load) begin
			out_q.distance     <= oload.sel_dist ? rd_dist : '0;
			out_q.status       <= oload.status;
			out_q.used_start_x <= oload.sel_xy ? used_x : '0;
			out_q.used_start_y <= oload.sel_xy ? used_y : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
